// ===== rtl/rpsh_pkg.sv =====
// Shared types, constants and report decoding for the retro pad scanner.
`default_nettype none

package rpsh_pkg;

  typedef enum logic [1:0] {
    MODE_DETECT = 2'd0,
    MODE_FOUR   = 2'd1,
    MODE_EIGHT  = 2'd2,
    MODE_FAULT  = 2'd3
  } rpsh_mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SETTLE   = 2'd0,
    CFG_DETECT   = 2'd1,
    CFG_POLL_GAP = 2'd2
  } rpsh_cfg_idx_e;

  localparam logic [3:0] PHASE_IDLE   = 4'd0;
  localparam logic [3:0] PHASE_FIRST  = 4'd1;
  localparam logic [3:0] PHASE_GAP    = 4'd9;
  localparam logic [3:0] PHASE_LAST4  = 4'd4;
  localparam logic [3:0] PHASE_LAST8  = 4'd8;
  localparam logic [3:0] HAT_RELEASED = 4'd8;

  localparam logic [3:0] ID_FOUR_TR   = 4'hB;
  localparam logic [3:0] ID_EIGHT_A   = 4'hC;
  localparam logic [3:0] ID_EIGHT_B   = 4'hD;
  localparam logic [3:0] ID_FOUR_OPEN = 4'hF;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [7:0]  detect_ticks;
    logic [15:0] poll_gap_ticks;
  } rpsh_cfg_t;

  typedef struct packed {
    logic        th_level;
    logic        tr_level;
    logic        tr_drive_enable;
    logic [1:0]  pad_kind;
    logic        report_valid;
    logic [15:0] report_word;
  } rpsh_result_t;

  // OR of neighboring data lines: bit1 from D3|D2, bit0 from D1|D0.
  function automatic logic [1:0] pair_nibble(input logic [5:0] p);
    pair_nibble = {p[3] | p[2], p[1] | p[0]};
  endfunction

  function automatic logic [3:0] hat_code(input logic up, input logic dn,
                                          input logic lt, input logic rt);
    logic [3:0] hat;
    if (up) begin
      hat = rt ? 4'd1 : (lt ? 4'd7 : 4'd0);
    end else if (dn) begin
      hat = rt ? 4'd3 : (lt ? 4'd5 : 4'd4);
    end else if (rt) begin
      hat = 4'd2;
    end else if (lt) begin
      hat = 4'd6;
    end else begin
      hat = HAT_RELEASED;
    end
    return hat;
  endfunction

  // Samples are raw line levels; buttons are active low on the lines.
  function automatic logic [15:0] build_report(
      input logic four, input logic [5:0] t0, input logic [5:0] t1,
      input logic [5:0] t2, input logic [5:0] t3, input logic [5:0] t5,
      input logic sh, input logic l3n, input logic r3n);
    logic up, dn, lt, rt, a, b, c, x, y, z, l, r, st;
    if (four) begin
      l  = ~t0[3];
      b  = ~t1[0]; c  = ~t1[1]; a  = ~t1[2]; st = ~t1[3];
      up = ~t2[0]; dn = ~t2[1]; lt = ~t2[2]; rt = ~t2[3];
      z  = ~t3[0]; y  = ~t3[1]; x  = ~t3[2]; r  = ~t3[3];
    end else begin
      z  = ~t5[0]; y  = ~t5[1]; x  = ~t5[2]; r  = ~t5[3];
      b  = ~t1[4]; c  = ~t1[5]; a  = ~t0[4]; st = ~t0[5];
      up = ~t1[0]; dn = ~t1[1]; lt = ~t1[2]; rt = ~t1[3];
      l  = 1'b0;
    end
    return {~r3n, ~l3n, st, sh, r, l, c, z, y, b, a, x, hat_code(up, dn, lt, rt)};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpsh_core.sv =====
// Pad scan sequencer: detection, phase stepping, sample store and result decode.
`default_nettype none

module rpsh_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire rpsh_pkg::rpsh_cfg_t   cfg_i,
  input  wire logic [5:0]            pad_lines_i,
  input  wire logic                  host_ready_i,
  input  wire logic                  share_line_i,
  input  wire logic                  left_stick_line_i,
  input  wire logic                  right_stick_line_i,
  output rpsh_pkg::rpsh_result_t     result_o
);

  rpsh_pkg::rpsh_mode_e mode_q, mode_d;
  logic        tr_driven_q, tr_driven_d;
  logic [3:0]  phase_q, phase_d;
  logic [15:0] wait_q, wait_d;
  logic [3:0]  id_q, id_d;

  // Only the samples that the decode reads later are kept; the final
  // sample of a four-phase scan is taken straight from the lines.
  logic [5:0]  s0_q, s1_q, s2_q, s5_q;
  logic        smp_en;

  logic [15:0] wait_inc;
  logic [3:0]  last_phase;
  logic [3:0]  k;
  logic        in_scan;
  logic        id_done;
  logic [3:0]  id_full;

  assign wait_inc   = wait_q + 16'd1;
  assign last_phase = (mode_q == rpsh_pkg::MODE_FOUR) ? rpsh_pkg::PHASE_LAST4
                                                      : rpsh_pkg::PHASE_LAST8;
  assign k          = phase_q - 4'd1;
  assign in_scan    = (phase_q >= rpsh_pkg::PHASE_FIRST) && (phase_q <= last_phase);
  assign id_full    = id_q | {2'b00, rpsh_pkg::pair_nibble(pad_lines_i)};

  always_comb begin
    mode_d      = mode_q;
    tr_driven_d = tr_driven_q;
    phase_d     = phase_q;
    wait_d      = wait_q;
    id_d        = id_q;
    smp_en      = 1'b0;
    id_done     = 1'b0;

    result_o.th_level        = 1'b1;
    result_o.tr_level        = 1'b1;
    result_o.tr_drive_enable = tr_driven_q;
    result_o.pad_kind        = mode_q;
    result_o.report_valid    = 1'b0;
    result_o.report_word     = 16'd0;

    unique case (mode_q)
      rpsh_pkg::MODE_DETECT: begin
        result_o.th_level = ~phase_q[0];
        if (wait_q >= {8'd0, cfg_i.detect_ticks}) begin
          if (!phase_q[0]) begin
            id_d    = {rpsh_pkg::pair_nibble(pad_lines_i), 2'b00};
            phase_d = rpsh_pkg::PHASE_FIRST;
          end else begin
            id_d    = id_full;
            id_done = 1'b1;
            phase_d = rpsh_pkg::PHASE_IDLE;
          end
          wait_d = 16'd0;
        end else begin
          wait_d = wait_inc;
        end
        if (id_done) begin
          case (id_full)
            rpsh_pkg::ID_FOUR_TR: begin
              mode_d = rpsh_pkg::MODE_FOUR;  tr_driven_d = 1'b1;
            end
            rpsh_pkg::ID_EIGHT_A, rpsh_pkg::ID_EIGHT_B: begin
              mode_d = rpsh_pkg::MODE_EIGHT; tr_driven_d = 1'b0;
            end
            rpsh_pkg::ID_FOUR_OPEN: begin
              mode_d = rpsh_pkg::MODE_FOUR;  tr_driven_d = 1'b0;
            end
            default: begin
              mode_d = rpsh_pkg::MODE_FAULT; tr_driven_d = 1'b0;
            end
          endcase
        end
      end
      rpsh_pkg::MODE_FOUR, rpsh_pkg::MODE_EIGHT: begin
        if (in_scan) begin
          if (mode_q == rpsh_pkg::MODE_FOUR) begin
            result_o.th_level = ~k[0];
            result_o.tr_level = ~k[1];
          end else begin
            result_o.th_level = phase_q[0];
          end
          if (wait_q >= {8'd0, cfg_i.settle_ticks}) begin
            smp_en = 1'b1;
            if (phase_q == last_phase) begin
              result_o.report_valid = 1'b1;
              result_o.report_word  = rpsh_pkg::build_report(
                  mode_q == rpsh_pkg::MODE_FOUR, s0_q, s1_q, s2_q, pad_lines_i,
                  s5_q, share_line_i, left_stick_line_i, right_stick_line_i);
              phase_d = rpsh_pkg::PHASE_GAP;
            end else begin
              phase_d = phase_q + 4'd1;
            end
            wait_d = 16'd0;
          end else begin
            wait_d = wait_inc;
          end
        end else if (phase_q == rpsh_pkg::PHASE_GAP) begin
          if (wait_q >= cfg_i.poll_gap_ticks) begin
            phase_d = rpsh_pkg::PHASE_IDLE;
            wait_d  = 16'd0;
          end else begin
            wait_d = wait_inc;
          end
        end else begin
          phase_d = host_ready_i ? rpsh_pkg::PHASE_FIRST : rpsh_pkg::PHASE_IDLE;
          wait_d  = 16'd0;
        end
      end
      default: begin
        // Fault: halted, lines stay released.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= rpsh_pkg::MODE_DETECT;
      tr_driven_q <= 1'b0;
      phase_q     <= rpsh_pkg::PHASE_IDLE;
      wait_q      <= 16'd0;
      id_q        <= 4'd0;
    end else if (accept_i) begin
      mode_q      <= mode_d;
      tr_driven_q <= tr_driven_d;
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      id_q        <= id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && smp_en) begin
      case (k[2:0])
        3'd0:    s0_q <= pad_lines_i;
        3'd1:    s1_q <= pad_lines_i;
        3'd2:    s2_q <= pad_lines_i;
        3'd5:    s5_q <= pad_lines_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/retro_pad_scan_to_hid_report_unit.sv =====
// Top level of the retro pad scanner: configuration registers, sequencer and result register.
`default_nettype none

// Each input item is one 1 us tick of the pad lines; it produces exactly one
// result item carrying the select line levels, the pad kind and, on the tick
// of the last scan sample, a 16-bit report. An item is taken every clock
// cycle: the sequencer updates its state in the cycle of acceptance and the
// result goes into a single output register, which is reloaded in the same
// cycle that its current item is taken, so a stall on the result side is the
// only thing that holds off input. Configuration writes take effect on the
// next item.
module retro_pad_scan_to_hid_report_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [5:0]  pad_lines_i,
  input  wire logic        host_ready_i,
  input  wire logic        share_line_i,
  input  wire logic        left_stick_line_i,
  input  wire logic        right_stick_line_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             th_level_o,
  output logic             tr_level_o,
  output logic             tr_drive_enable_o,
  output logic [1:0]       pad_kind_o,
  output logic             report_valid_o,
  output logic [15:0]      report_word_o
);

  rpsh_pkg::rpsh_cfg_t    cfg_q;
  rpsh_pkg::rpsh_result_t result, res_q;
  logic                   out_valid_q;
  logic                   accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks   <= 8'd20;
      cfg_q.detect_ticks   <= 8'd2;
      cfg_q.poll_gap_ticks <= 16'd16000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rpsh_pkg::CFG_SETTLE:   cfg_q.settle_ticks   <= cfg_data_i[7:0];
        rpsh_pkg::CFG_DETECT:   cfg_q.detect_ticks   <= cfg_data_i[7:0];
        rpsh_pkg::CFG_POLL_GAP: cfg_q.poll_gap_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rpsh_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .cfg_i              (cfg_q),
    .pad_lines_i        (pad_lines_i),
    .host_ready_i       (host_ready_i),
    .share_line_i       (share_line_i),
    .left_stick_line_i  (left_stick_line_i),
    .right_stick_line_i (right_stick_line_i),
    .result_o           (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign th_level_o        = res_q.th_level;
  assign tr_level_o        = res_q.tr_level;
  assign tr_drive_enable_o = res_q.tr_drive_enable;
  assign pad_kind_o        = res_q.pad_kind;
  assign report_valid_o    = res_q.report_valid;
  assign report_word_o     = res_q.report_word;

endmodule

`default_nettype wire

// ===== rtl/rpsh_checker.sv =====
// Port-level checker for the retro pad scanner and its bind to the top level.
`default_nettype none

module rpsh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        th_level_o,
  input wire logic        tr_level_o,
  input wire logic        tr_drive_enable_o,
  input wire logic [1:0]  pad_kind_o,
  input wire logic        report_valid_o,
  input wire logic [15:0] report_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(report_word_o)
      && $stable(report_valid_o) && $stable(pad_kind_o))
    else $error("result item changed while stalled");

  a_report_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_valid_o |->
      pad_kind_o == rpsh_pkg::MODE_FOUR || pad_kind_o == rpsh_pkg::MODE_EIGHT)
    else $error("report while detecting or halted");

  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_valid_o |-> report_word_o == 16'd0)
    else $error("report word not cleared without a report");

  a_fault_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pad_kind_o == rpsh_pkg::MODE_FAULT |->
      th_level_o && tr_level_o && !tr_drive_enable_o)
    else $error("select lines active in fault");

  a_tr_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tr_drive_enable_o |-> pad_kind_o == rpsh_pkg::MODE_FOUR)
    else $error("TR driven for a pad that does not use it");

endmodule

bind retro_pad_scan_to_hid_report_unit rpsh_checker u_rpsh_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .th_level_o        (th_level_o),
  .tr_level_o        (tr_level_o),
  .tr_drive_enable_o (tr_drive_enable_o),
  .pad_kind_o        (pad_kind_o),
  .report_valid_o    (report_valid_o),
  .report_word_o     (report_word_o)
);

`default_nettype wire
